FILE: design/cal_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cal_pkg
// Shared types and constants for the connection admission limiter.
// ============================================================================
package cal_pkg;

    localparam int CAL_TABLE_ENTRIES = 32;

    localparam logic [8:0]  CAL_LIMIT_RESET = 9'd10;
    localparam logic [15:0] CAL_DELAY_RESET = 16'd10;

    // configuration register indexes
    localparam logic CFG_PER_SOURCE_LIMIT = 1'b0;
    localparam logic CFG_MIN_DELAY        = 1'b1;

    // item commands
    localparam logic CMD_CONNECT = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_ACCEPTED   = 3'd0,
        ST_SRC_REJECT = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_RELEASED   = 3'd3,
        ST_NOT_FOUND  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // one session table entry
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] id;
        logic [31:0] start;
        logic [31:0] log;
    } t_entry;

    typedef struct packed {
        logic [8:0]  per_source_limit;
        logic [15:0] busy_hold;
    } t_cfg;

endpackage

FILE: design/cal_table.sv
`timescale 1ns / 1ps
// ============================================================================
// cal_table
// Session table memory: one write port, one read port with a registered
// read. Per-entry valid bits make unwritten entries read as zero.
// ============================================================================
module cal_table
    import cal_pkg::*;
#(
    parameter int TABLE_ENTRIES = CAL_TABLE_ENTRIES,
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic [IW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry                   mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    t_entry                   r_rd_data;
    logic                     r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // an entry never written reads as the cleared value
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

FILE: design/cal_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// cal_ctrl
// Scan sequencer: walks the table one entry a cycle, counts busy entries of
// the source, picks the free entry, then writes back and issues the result.
// ============================================================================
module cal_ctrl
    import cal_pkg::*;
#(
    parameter int TABLE_ENTRIES = CAL_TABLE_ENTRIES,
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_start,
    input  logic          i_cmd,
    input  logic [31:0]   i_source_addr,
    input  logic [31:0]   i_now_time,
    input  logic [31:0]   i_session_id,
    output logic          o_busy,
    output logic [IW-1:0] o_rd_addr,
    input  t_entry        i_rd_data,
    output logic          o_wr_en,
    output logic [IW-1:0] o_wr_addr,
    output t_entry        o_wr_data,
    output logic          o_done,
    output t_status       o_status,
    output logic [7:0]    o_entry_index,
    output logic          o_log_event
);

    t_state r_state, n_state;

    logic          r_cmd;
    logic [31:0]   r_addr, r_now, r_sid;
    logic [CW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_eidx;
    logic          r_pend, n_pend;
    logic [8:0]    r_cnt, n_cnt;
    logic          r_free_ok, n_free_ok;
    logic [IW-1:0] r_free_idx, n_free_idx;
    logic          r_hit, n_hit;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    t_entry        r_hit_word, n_hit_word;
    logic          r_done, n_done;
    t_status       r_status, n_status;
    logic [7:0]    r_index, n_index;
    logic          r_log, n_log;

    logic        ev, busy_e, rel_hit, match_e, trip, stop, last, log_ok;
    logic [8:0]  cnt_inc;
    logic [31:0] age_start, age_log, delay32;

    assign delay32   = {16'd0, i_cfg.busy_hold};
    assign ev        = (r_state == S_SCAN) && r_pend;
    assign age_start = r_now - i_rd_data.start;
    assign busy_e    = (i_rd_data.id != 32'd0) ||
                       ((i_rd_data.start != 32'd0) && (age_start < delay32));
    assign rel_hit   = ev && (r_cmd == CMD_RELEASE) && (r_sid != 32'd0) &&
                       (i_rd_data.id == r_sid);
    assign match_e   = ev && (r_cmd == CMD_CONNECT) && busy_e &&
                       (i_rd_data.addr == r_addr);
    assign cnt_inc   = r_cnt + 9'd1;
    assign trip      = match_e && (cnt_inc > i_cfg.per_source_limit);
    assign stop      = rel_hit || trip;
    assign last      = ev && (r_eidx == IW'(TABLE_ENTRIES - 1));
    assign age_log   = r_now - r_hit_word.log;
    assign log_ok    = (r_hit_word.log == 32'd0) || (age_log >= delay32);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (stop || last) n_state = S_FINISH;
            end
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // memory access and handshake outputs
    always_comb begin
        o_busy    = (r_state != S_IDLE);
        o_rd_addr = (r_idx < CW'(TABLE_ENTRIES)) ? r_idx[IW-1:0] : '0;
        o_wr_en   = 1'b0;
        o_wr_addr = r_hit_idx;
        o_wr_data = r_hit_word;
        case (r_state)
            S_FINISH: begin
                if (r_cmd == CMD_RELEASE) begin
                    o_wr_en      = r_hit;
                    o_wr_data.id = 32'd0;
                end else if (r_hit) begin
                    o_wr_en       = log_ok;
                    o_wr_data.log = r_now;
                end else begin
                    o_wr_en   = r_free_ok;
                    o_wr_addr = r_free_idx;
                    o_wr_data = '{addr: r_addr, id: r_sid, start: r_now, log: 32'd0};
                end
            end
            default: ;
        endcase
    end

    // scan datapath and result
    always_comb begin
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_cnt      = r_cnt;
        n_free_ok  = r_free_ok;
        n_free_idx = r_free_idx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_word = r_hit_word;
        n_done     = 1'b0;
        n_status   = r_status;
        n_index    = r_index;
        n_log      = r_log;
        case (r_state)
            S_IDLE: begin
                n_idx     = '0;
                n_pend    = 1'b0;
                n_cnt     = '0;
                n_free_ok = 1'b0;
                n_hit     = 1'b0;
            end
            S_SCAN: begin
                // advance the read address; its data lands in the next cycle
                n_pend = (r_idx < CW'(TABLE_ENTRIES));
                n_idx  = r_idx + CW'(1);
                if (match_e) n_cnt = cnt_inc;
                if (ev && (r_cmd == CMD_CONNECT) && !busy_e && !r_free_ok) begin
                    n_free_ok  = 1'b1;
                    n_free_idx = r_eidx;
                end
                if (stop) begin
                    n_hit      = 1'b1;
                    n_hit_idx  = r_eidx;
                    n_hit_word = i_rd_data;
                end
            end
            S_FINISH: begin
                n_done = 1'b1;
                if (r_cmd == CMD_RELEASE) begin
                    n_status = r_hit ? ST_RELEASED : ST_NOT_FOUND;
                    n_index  = r_hit ? 8'(r_hit_idx) : 8'd0;
                    n_log    = 1'b0;
                end else if (r_hit) begin
                    n_status = ST_SRC_REJECT;
                    n_index  = 8'(r_hit_idx);
                    n_log    = log_ok;
                end else if (!r_free_ok) begin
                    n_status = ST_TABLE_FULL;
                    n_index  = 8'd0;
                    n_log    = 1'b1;
                end else begin
                    n_status = ST_ACCEPTED;
                    n_index  = 8'(r_free_idx);
                    n_log    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_start) begin
            r_cmd  <= i_cmd;
            r_addr <= i_source_addr;
            r_now  <= i_now_time;
            r_sid  <= i_session_id;
        end
        r_eidx     <= r_idx[IW-1:0];
        r_idx      <= n_idx;
        r_cnt      <= n_cnt;
        r_free_ok  <= n_free_ok;
        r_free_idx <= n_free_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_hit_word <= n_hit_word;
        r_status   <= n_status;
        r_index    <= n_index;
        r_log      <= n_log;
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_entry_index = r_index;
    assign o_log_event   = r_log;

endmodule

FILE: design/connection_admission_limiter.sv
`timescale 1ns / 1ps
// ============================================================================
// connection_admission_limiter
// Per-source connection admission control over a fixed session table.
// ============================================================================
// Pulse start with a beat (cmd, source_addr, now_time, session_id) while busy
// is low. A connect scans the table in order, counting live or recently
// started entries of the same source; past per_source_limit it is rejected
// with a rate-limited log flag, else the first free entry takes the session
// or the table is full. A release zeroes the id in the first entry holding it.
// Each beat gives exactly one result, shown for one cycle with o_done high;
// the receiver cannot stall it, so capture it on that cycle. Sequence: the
// beat is accepted, then the scan reads the table memory one entry a cycle
// through its single read port, stopping early when a release finds its id
// or the limit trips, then a write-back state, and o_done the cycle after;
// busy drops as o_done rises, so the next start may come in that cycle. The
// table reads as cleared right after reset; no clearing pass is needed.
// Write configuration only while idle.
// ============================================================================
module connection_admission_limiter
    import cal_pkg::*;
#(
    parameter int TABLE_ENTRIES = CAL_TABLE_ENTRIES,
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // command beat
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [31:0] i_source_addr,
    input  logic [31:0] i_now_time,
    input  logic [31:0] i_session_id,
    // result beat
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [7:0]  o_entry_index,
    output logic        o_log_event
);

    t_cfg          r_cfg;
    logic [IW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    t_entry        rd_data, wr_data;
    t_status       status;

    // hold configuration; the user must write it only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.per_source_limit <= CAL_LIMIT_RESET;
            r_cfg.busy_hold        <= CAL_DELAY_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PER_SOURCE_LIMIT: r_cfg.per_source_limit <= i_cfg_data[8:0];
                CFG_MIN_DELAY:        r_cfg.busy_hold        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cal_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    cal_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_start       (start),
        .i_cmd         (i_cmd),
        .i_source_addr (i_source_addr),
        .i_now_time    (i_now_time),
        .i_session_id  (i_session_id),
        .o_busy        (busy),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_done        (o_done),
        .o_status      (status),
        .o_entry_index (o_entry_index),
        .o_log_event   (o_log_event)
    );

    assign o_status = status;

    // an accepted beat keeps the block busy until its result
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // a result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a pending beat");

    // release outcomes never log
    a_release_no_log: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ((status == ST_RELEASED) || (status == ST_NOT_FOUND)))
            |-> !o_log_event)
        else $error("release result raised log flag");

    // table full always logs and points at entry zero
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (status == ST_TABLE_FULL))
            |-> (o_log_event && (o_entry_index == 8'd0)))
        else $error("table-full result malformed");

endmodule
